// ----- rtl/bcqa_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the balanced class quota allocator
package bcqa_pkg;

	localparam int DEF_MAX_CLASSES = 64;
	localparam int DEF_COUNT_BITS  = 24;

	localparam int LABEL_W    = 6;
	localparam int QUOTA_W    = 24;
	localparam int BUDGET_W   = 24;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;

	localparam int QUEUE_DEPTH = 4;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_TOP_CLASS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BUDGET    = 1'b1;

	localparam logic [LABEL_W-1:0]  TOP_RESET    = 6'd63;
	localparam logic [BUDGET_W-1:0] BUDGET_RESET = 24'd0;

	// one classified item as it sits in the queue
	typedef struct packed {
		logic [LABEL_W-1:0] label;
		logic               hit;
		logic               last;
	} fe_t;

endpackage

// ----- rtl/bcqa_if.sv -----
`timescale 1ns / 1ps
// channel interfaces: label input, quota output and configuration write
interface bcqa_in_if;
	import bcqa_pkg::*;
	logic               valid;
	logic               ready;
	logic [LABEL_W-1:0] class_label;
	logic               last_item;
	modport source (output valid, output class_label, output last_item, input ready);
	modport sink (input valid, input class_label, input last_item, output ready);
endinterface

interface bcqa_out_if;
	import bcqa_pkg::*;
	logic               valid;
	logic               ready;
	logic [LABEL_W-1:0] class_index;
	logic [QUOTA_W-1:0] quota;
	logic               last_quota;
	modport source (output valid, output class_index, output quota, output last_quota,
		input ready);
	modport sink (input valid, input class_index, input quota, input last_quota,
		output ready);
endinterface

interface bcqa_cfg_if;
	import bcqa_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/bcqa_front.sv -----
`timescale 1ns / 1ps
// front end: configuration registers, item accept and range classification
module bcqa_front #(
	parameter int MAX_CLASSES = bcqa_pkg::DEF_MAX_CLASSES
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	bcqa_in_if.sink                                in_ch,
	bcqa_cfg_if.sink                               cfg_ch,
	input  logic                                   q_full,
	output logic                                   q_push,
	output bcqa_pkg::fe_t                          q_data,
	output logic [$clog2(MAX_CLASSES)-1:0]         top_eff,
	output logic [bcqa_pkg::BUDGET_W-1:0]          budget
);
	import bcqa_pkg::*;

	localparam int CW = $clog2(MAX_CLASSES);
	localparam logic [LABEL_W-1:0] TOP_CAP = LABEL_W'(MAX_CLASSES - 1);

	logic [LABEL_W-1:0]  top_q;
	logic [BUDGET_W-1:0] budget_q;
	logic [LABEL_W-1:0]  top_lim;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q    <= TOP_RESET;
			budget_q <= BUDGET_RESET;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				REG_TOP_CLASS: top_q    <= cfg_ch.data[LABEL_W-1:0];
				REG_BUDGET:    budget_q <= cfg_ch.data[BUDGET_W-1:0];
				default: ;
			endcase
		end
	end

	// top class clamped to the histogram size
	assign top_lim = (top_q > TOP_CAP) ? TOP_CAP : top_q;
	assign top_eff = top_lim[CW-1:0];
	assign budget  = budget_q;

	assign in_ch.ready = !q_full;
	assign q_push      = in_ch.valid && !q_full;
	assign q_data      = '{label: in_ch.class_label,
		hit: (in_ch.class_label <= top_lim),
		last: in_ch.last_item};

endmodule

// ----- rtl/bcqa_fifo.sv -----
`timescale 1ns / 1ps
// short item queue between front and back end
module bcqa_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bcqa_pkg::fe_t push_data,
	output logic          full,
	input  logic          pop,
	output bcqa_pkg::fe_t pop_data,
	output logic          empty
);
	import bcqa_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	fe_t           slot_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [NW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full     = (cnt_q == NW'(QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/bcqa_div.sv -----
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module bcqa_div #(
	parameter int NW = bcqa_pkg::BUDGET_W,
	parameter int DW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient
);
	localparam int KW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [KW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   rem_sh;
	logic [DW:0]   diff;
	logic          ge;

	assign rem_sh = {rem_q, num_q[NW-1]};
	assign ge     = (rem_sh >= {1'b0, den_q});
	assign diff   = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			num_q  <= dividend;
			rem_q  <= '0;
			den_q  <= divisor;
			cnt_q  <= KW'(NW);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
			num_q <= {num_q[NW-2:0], ge};
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == KW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

// ----- rtl/bcqa_back.sv -----
`timescale 1ns / 1ps
// back end: histogram update, quota allocation and quota emission
module bcqa_back #(
	parameter int MAX_CLASSES = bcqa_pkg::DEF_MAX_CLASSES,
	parameter int COUNT_BITS  = bcqa_pkg::DEF_COUNT_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [$clog2(MAX_CLASSES)-1:0] top_eff,
	input  logic [bcqa_pkg::BUDGET_W-1:0]  budget,
	input  logic                           q_valid,
	input  bcqa_pkg::fe_t                  q_data,
	output logic                           q_pop,
	bcqa_out_if.source                     out_ch
);
	import bcqa_pkg::*;

	localparam int CW = $clog2(MAX_CLASSES);
	localparam int KW = $clog2(MAX_CLASSES + 1);
	localparam int WW = (COUNT_BITS > QUOTA_W) ? COUNT_BITS : QUOTA_W;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_DRAIN,
		ST_INIT,
		ST_SCAN,
		ST_SCAN_END,
		ST_DIV_WAIT,
		ST_GRANT,
		ST_EMIT_RD,
		ST_EMIT_WR
	} state_t;

	state_t state_q;

	// histogram memory, entries without a valid bit read as zero
	logic [COUNT_BITS-1:0]  hist_mem [MAX_CLASSES];
	logic [COUNT_BITS-1:0]  hist_rd_q;
	logic [MAX_CLASSES-1:0] hval_q;
	logic [MAX_CLASSES-1:0] pend_q;

	// quota memory
	logic [QUOTA_W-1:0] quota_mem [MAX_CLASSES];
	logic [QUOTA_W-1:0] quota_rd_q;

	// count update pipeline
	logic                  upd_s1;
	logic [CW-1:0]         lbl_s1;
	logic                  wr_v_q;
	logic [CW-1:0]         wr_lbl_q;
	logic [COUNT_BITS-1:0] wr_data_q;
	logic [COUNT_BITS-1:0] base;
	logic [COUNT_BITS-1:0] inc_val;

	// scan pipeline
	logic                  scan_s1;
	logic [CW-1:0]         sc_s1;

	logic [CW-1:0]         ic_q;
	logic [CW-1:0]         sc_q;
	logic [CW-1:0]         ec_q;
	logic [BUDGET_W-1:0]   budget_left_q;
	logic [KW-1:0]         classes_left_q;
	logic [KW-1:0]         cl_inc;
	logic [COUNT_BITS-1:0] min_q;
	logic [CW-1:0]         pick_q;
	logic                  found_q;

	logic                  hrd_en;
	logic [CW-1:0]         hrd_addr;

	logic                  div_start;
	logic                  div_done;
	logic [BUDGET_W-1:0]   share;
	logic [WW-1:0]         grant_w;
	logic [QUOTA_W-1:0]    grant;

	logic                  out_v_q;
	logic [LABEL_W-1:0]    out_idx_q;
	logic [QUOTA_W-1:0]    out_quota_q;
	logic                  out_last_q;
	logic                  out_free;

	assign q_pop    = (state_q == ST_LOAD) && q_valid;
	assign hrd_en   = (q_pop && q_data.hit) || (state_q == ST_SCAN);
	assign hrd_addr = (state_q == ST_SCAN) ? sc_q : q_data.label[CW-1:0];

	// forward the previous write when the same class follows
	assign base = (wr_v_q && (wr_lbl_q == lbl_s1)) ? wr_data_q :
		(hval_q[lbl_s1] ? hist_rd_q : '0);
	assign inc_val = (base == '1) ? base : base + 1'b1;

	assign cl_inc = classes_left_q + KW'(hval_q[ic_q]);

	assign div_start = (state_q == ST_SCAN_END);
	assign grant_w   = (WW'(min_q) < WW'(share)) ? WW'(min_q) : WW'(share);
	assign grant     = grant_w[QUOTA_W-1:0];

	assign out_free = !out_v_q || out_ch.ready;

	bcqa_div #(
		.NW (BUDGET_W),
		.DW (KW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (budget_left_q),
		.divisor  (classes_left_q),
		.done     (div_done),
		.quotient (share)
	);

	always_ff @(posedge clk) begin
		if (upd_s1) begin
			hist_mem[lbl_s1] <= inc_val;
		end
		if (hrd_en) begin
			hist_rd_q <= hist_mem[hrd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_GRANT) begin
			quota_mem[pick_q] <= grant;
		end
		if (state_q == ST_EMIT_RD) begin
			quota_rd_q <= quota_mem[ec_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_LOAD;
			hval_q         <= '0;
			pend_q         <= '0;
			upd_s1         <= 1'b0;
			lbl_s1         <= '0;
			wr_v_q         <= 1'b0;
			wr_lbl_q       <= '0;
			wr_data_q      <= '0;
			scan_s1        <= 1'b0;
			sc_s1          <= '0;
			ic_q           <= '0;
			sc_q           <= '0;
			ec_q           <= '0;
			budget_left_q  <= '0;
			classes_left_q <= '0;
			min_q          <= '0;
			pick_q         <= '0;
			found_q        <= 1'b0;
			out_v_q        <= 1'b0;
			out_idx_q      <= '0;
			out_quota_q    <= '0;
			out_last_q     <= 1'b0;
		end else begin
			upd_s1  <= q_pop && q_data.hit;
			lbl_s1  <= q_data.label[CW-1:0];
			wr_v_q  <= upd_s1;
			scan_s1 <= (state_q == ST_SCAN);
			sc_s1   <= sc_q;

			if (upd_s1) begin
				hval_q[lbl_s1] <= 1'b1;
				wr_lbl_q       <= lbl_s1;
				wr_data_q      <= inc_val;
			end

			// running minimum over pending classes, lower index wins ties
			if (scan_s1 && pend_q[sc_s1] && (!found_q || hist_rd_q < min_q)) begin
				min_q   <= hist_rd_q;
				pick_q  <= sc_s1;
				found_q <= 1'b1;
			end

			if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end

			unique case (state_q)
				ST_LOAD: begin
					if (q_pop && q_data.last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					budget_left_q  <= budget;
					classes_left_q <= '0;
					ic_q           <= '0;
					state_q        <= ST_INIT;
				end
				ST_INIT: begin
					pend_q[ic_q]   <= hval_q[ic_q];
					classes_left_q <= cl_inc;
					if (ic_q == top_eff) begin
						if (cl_inc == '0) begin
							ec_q    <= '0;
							state_q <= ST_EMIT_RD;
						end else begin
							sc_q    <= '0;
							found_q <= 1'b0;
							state_q <= ST_SCAN;
						end
					end else begin
						ic_q <= ic_q + 1'b1;
					end
				end
				ST_SCAN: begin
					sc_q <= sc_q + 1'b1;
					if (sc_q == top_eff) begin
						state_q <= ST_SCAN_END;
					end
				end
				ST_SCAN_END: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						state_q <= ST_GRANT;
					end
				end
				ST_GRANT: begin
					pend_q[pick_q] <= 1'b0;
					budget_left_q  <= budget_left_q - grant;
					classes_left_q <= classes_left_q - 1'b1;
					if (classes_left_q == KW'(1)) begin
						ec_q    <= '0;
						state_q <= ST_EMIT_RD;
					end else begin
						sc_q    <= '0;
						found_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_WR;
				end
				ST_EMIT_WR: begin
					if (out_free) begin
						out_v_q     <= 1'b1;
						out_idx_q   <= LABEL_W'(ec_q);
						out_quota_q <= hval_q[ec_q] ? quota_rd_q : '0;
						out_last_q  <= (ec_q == top_eff);
						if (ec_q == top_eff) begin
							hval_q  <= '0;
							state_q <= ST_LOAD;
						end else begin
							ec_q    <= ec_q + 1'b1;
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign out_ch.valid       = out_v_q;
	assign out_ch.class_index = out_idx_q;
	assign out_ch.quota       = out_quota_q;
	assign out_ch.last_quota  = out_last_q;

endmodule

// ----- rtl/balanced_class_quota_allocator_top.sv -----
`timescale 1ns / 1ps
// top level of the balanced class quota allocator
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+------------------------------------------
//  in_ch    | in  | valid / ready | class_label[5:0], last_item
//  out_ch   | out | valid / ready | class_index[5:0], quota[23:0], last_quota
//  cfg_ch   | in  | valid / ready | index[0] (0 top class, 1 budget), data[23:0]
//
// labels are taken one per cycle while the back end is loading counts
// the item marked last starts allocation: a setup pass over the classes, then,
//   for each class that holds items, a min scan over the count memory through
//   its single read port, a 24 bit bit-serial divide of the budget left by the
//   classes left, and a grant
// quotas then leave one per class from 0 to the top class
// the front keeps taking items into a four entry queue during allocation
// reset is asynchronous, active low; histogram valid bits clear at once, no sweep
// out_ch stalls hold the output register; in_ch stalls once the queue fills
module balanced_class_quota_allocator_top #(
	parameter int MAX_CLASSES = bcqa_pkg::DEF_MAX_CLASSES,
	parameter int COUNT_BITS  = bcqa_pkg::DEF_COUNT_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	bcqa_in_if.sink     in_ch,
	bcqa_out_if.source  out_ch,
	bcqa_cfg_if.sink    cfg_ch
);
	import bcqa_pkg::*;

	localparam int CW = $clog2(MAX_CLASSES);

	// front to queue
	logic          q_push;
	fe_t           q_push_data;
	logic          q_full;

	// queue to back
	logic          q_pop;
	fe_t           q_pop_data;
	logic          q_empty;

	// configuration seen by the back end
	logic [CW-1:0]       top_eff;
	logic [BUDGET_W-1:0] budget;

	bcqa_front #(
		.MAX_CLASSES (MAX_CLASSES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.cfg_ch  (cfg_ch),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_data  (q_push_data),
		.top_eff (top_eff),
		.budget  (budget)
	);

	bcqa_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.empty     (q_empty)
	);

	// count update, min scan, divide and quota output
	bcqa_back #(
		.MAX_CLASSES (MAX_CLASSES),
		.COUNT_BITS  (COUNT_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.top_eff (top_eff),
		.budget  (budget),
		.q_valid (!q_empty),
		.q_data  (q_pop_data),
		.q_pop   (q_pop),
		.out_ch  (out_ch)
	);

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the balanced class quota allocator
module testbench;
	import bcqa_pkg::*;

	localparam int NCLS           = DEF_MAX_CLASSES;
	localparam int CNT_W          = DEF_COUNT_BITS;
	// longest quiet stretch of a correct run is one allocation over all classes
	// plus a long output stall, so this is several times over
	localparam int WATCHDOG_LIMIT = 50000;
	// covers the four entry front queue and the allocation setup
	localparam int DRAIN_PAUSE    = 100;
	localparam int RANDOM_ITEMS   = 257;

	// one quota as it leaves the block
	typedef struct packed {
		logic [LABEL_W-1:0] cls;
		logic [QUOTA_W-1:0] quota;
		logic               tail;
	} quota_rec_t;

	logic clk = 1'b0;
	logic arst_n;

	bcqa_in_if  in_ch ();
	bcqa_out_if out_ch ();
	bcqa_cfg_if cfg_ch ();

	balanced_class_quota_allocator_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow of the block: registers, per-class counts and the quotas still due
	logic [LABEL_W-1:0]  top_reg    = TOP_RESET;
	logic [BUDGET_W-1:0] budget_reg = BUDGET_RESET;
	logic [CNT_W-1:0]    class_count [NCLS];
	quota_rec_t          quota_expect [$];

	int  mismatch_cnt = 0;
	int  hold_left    = 0;
	int  quiet_cycles = 0;
	// set for whole data sets: no gaps on either side
	logic steady = 1'b0;

	initial begin
		for (int c = 0; c < NCLS; c++)
			class_count[c] = '0;
	end

	// gap length in cycles: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// count one accepted item; on the last item share the budget and queue
	// one quota per class from 0 to the top class
	function automatic void account_item(input logic [LABEL_W-1:0] lbl, input logic lst);
		logic [CNT_W-1:0]    pending [NCLS];
		logic [QUOTA_W-1:0]  plan [NCLS];
		logic [BUDGET_W-1:0] left;
		logic [BUDGET_W-1:0] share;
		logic [BUDGET_W-1:0] grant;
		int                  top;
		int                  open_cnt;
		int                  pick;
		quota_rec_t          rec;
		// a top beyond the capacity falls back to the last class
		top = (int'(top_reg) > NCLS - 1) ? NCLS - 1 : int'(top_reg);
		// labels above the top class are dropped, counts stop at all ones
		if (int'(lbl) <= top && class_count[lbl] != '1)
			class_count[lbl]++;
		if (!lst)
			return;
		left = budget_reg;
		open_cnt = 0;
		for (int c = 0; c <= top; c++) begin
			pending[c] = class_count[c];
			if (pending[c] != '0)
				open_cnt++;
			else
				plan[c] = '0;
		end
		// rarest class first, ties to the lower index
		while (open_cnt != 0) begin
			pick = -1;
			for (int c = 0; c <= top; c++) begin
				if (pending[c] != '0 && (pick < 0 || pending[c] < pending[pick]))
					pick = c;
			end
			share = BUDGET_W'(left / open_cnt);
			grant = (pending[pick] < share) ? pending[pick] : share;
			plan[pick] = grant;
			pending[pick] = '0;
			left = left - grant;
			open_cnt--;
		end
		for (int c = 0; c <= top; c++) begin
			rec.cls   = c[LABEL_W-1:0];
			rec.quota = plan[c];
			rec.tail  = (c == top);
			quota_expect.push_back(rec);
		end
		// histogram is cleared whole, classes above the top too
		for (int c = 0; c < NCLS; c++)
			class_count[c] = '0;
	endfunction

	// offer one item after a random gap; valid stays high afterwards so the
	// next item can follow without a bubble
	task automatic send_item(input logic [LABEL_W-1:0] lbl, input logic lst);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.class_label <= lbl;
		in_ch.last_item   <= lst;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		account_item(lbl, lst);
	endtask

	// stop offering items, let every quota arrive and the front queue drain
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (quota_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	// write both registers back to back in random order; only called when idle
	task automatic configure(input int top_val, input logic [BUDGET_W-1:0] budget_val);
		logic [CFG_DATA_W-1:0] value [2];
		logic [CFG_IDX_W-1:0]  idx [2];
		int                    swap;
		// upper data bits of a top class write carry noise
		value[0] = CFG_DATA_W'($urandom());
		value[0][LABEL_W-1:0] = top_val[LABEL_W-1:0];
		idx[0]   = REG_TOP_CLASS;
		value[1] = budget_val;
		idx[1]   = REG_BUDGET;
		swap = $urandom_range(0, 1);
		for (int k = 0; k < 2; k++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx[k ^ swap];
			cfg_ch.data  <= value[k ^ swap];
			@(posedge clk);
			while (!cfg_ch.ready)
				@(posedge clk);
		end
		cfg_ch.valid <= 1'b0;
		top_reg    = top_val[LABEL_W-1:0];
		budget_reg = budget_val;
	endtask

	// reset values in use: top class 63, budget 0, so every quota is 0
	task automatic test_reset_defaults();
		send_item(6'd0, 1'b0);
		send_item(6'd63, 1'b1);
		wait_drained();
	endtask

	// huge budget: quotas equal the counts; stray labels and an ignored last label
	task automatic test_budget_split();
		configure(3, '1);
		send_item(6'd0, 1'b0);
		send_item(6'd1, 1'b0);
		send_item(6'd1, 1'b0);
		send_item(6'd2, 1'b0);
		send_item(6'd2, 1'b0);
		send_item(6'd2, 1'b0);
		send_item(6'd40, 1'b0);
		send_item(6'd62, 1'b1);
		wait_drained();
	endtask

	// budget smaller than the class count: floor division grants 0 to most
	task automatic test_small_budget();
		configure(5, 24'd2);
		send_item(6'd0, 1'b0);
		send_item(6'd1, 1'b0);
		send_item(6'd2, 1'b0);
		send_item(6'd3, 1'b0);
		send_item(6'd4, 1'b0);
		send_item(6'd4, 1'b1);
		wait_drained();
	endtask

	// single class: an empty data set, one counted item, then another empty data set
	task automatic test_single_class();
		configure(0, 24'd5);
		send_item(6'd63, 1'b1);
		send_item(6'd0, 1'b1);
		send_item(6'd1, 1'b1);
		wait_drained();
	endtask

	// counts held above a top class that is then lowered; tie between 1 and 2
	task automatic test_top_lowered();
		configure(7, 24'd100);
		send_item(6'd6, 1'b0);
		send_item(6'd7, 1'b0);
		send_item(6'd2, 1'b0);
		wait_drained();
		configure(4, 24'd100);
		send_item(6'd1, 1'b1);
		wait_drained();
	endtask

	// random data sets, back to back, with new settings now and then
	task automatic test_random_sets(input int item_goal);
		int                  sent;
		int                  set_len;
		int                  top_pick;
		int                  r;
		logic [BUDGET_W-1:0] budget_pick;
		logic [LABEL_W-1:0]  lbl;
		sent = 0;
		while (sent < item_goal) begin
			steady = ($urandom_range(0, 3) == 0);
			if (sent == 0 || $urandom_range(0, 2) == 0) begin
				wait_drained();
				r = $urandom_range(0, 9);
				if (r < 2)
					top_pick = NCLS - 1;
				else if (r < 3)
					top_pick = 0;
				else
					top_pick = $urandom_range(1, 15);
				r = $urandom_range(0, 9);
				if (r < 2)
					budget_pick = '1;
				else if (r < 3)
					budget_pick = '0;
				else if (r < 7)
					budget_pick = BUDGET_W'($urandom_range(1, 24));
				else
					budget_pick = BUDGET_W'($urandom());
				configure(top_pick, budget_pick);
			end
			set_len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) :
				$urandom_range(13, 40);
			for (int i = 0; i < set_len; i++) begin
				// mostly labels in use, some anywhere in the label range
				if ($urandom_range(0, 99) < 85)
					lbl = LABEL_W'($urandom_range(0, int'(top_reg)));
				else
					lbl = LABEL_W'($urandom_range(0, NCLS - 1));
				send_item(lbl, i == set_len - 1);
				sent++;
			end
		end
		steady = 1'b0;
	endtask

	// result side: random back pressure
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			out_ch.ready <= 1'b1;
			if ($urandom_range(0, 2) == 0)
				hold_left <= pick_gap();
		end
	end

	// compare every accepted quota with the oldest one due
	always @(posedge clk) begin
		quota_rec_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (quota_expect.size() == 0) begin
				if (mismatch_cnt < 10)
					$display("%0t: unexpected quota: class %0d quota %0d last %0b", $realtime,
						out_ch.class_index, out_ch.quota, out_ch.last_quota);
				mismatch_cnt++;
			end else begin
				want = quota_expect.pop_front();
				if (out_ch.class_index !== want.cls || out_ch.quota !== want.quota ||
						out_ch.last_quota !== want.tail) begin
					if (mismatch_cnt < 10)
						$display({"%0t: quota mismatch: expected class %0d quota %0d",
							" last %0b, got class %0d quota %0d last %0b"},
							$realtime, want.cls, want.quota, want.tail,
							out_ch.class_index, out_ch.quota, out_ch.last_quota);
					mismatch_cnt++;
				end
			end
		end
	end

	// watchdog: too long without any handshake on any channel
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		// every input known from time zero
		arst_n            = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.class_label = '0;
		in_ch.last_item   = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = REG_TOP_CLASS;
		cfg_ch.data       = '0;
		out_ch.ready      = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_budget_split();
		test_small_budget();
		test_single_class();
		test_top_lowered();
		test_random_sets(RANDOM_ITEMS);

		wait_drained();
		if (mismatch_cnt == 0 && quota_expect.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
